@@ hw/rtl/lhp_pkg.sv @@
`timescale 1ns / 1ps

package lhp_pkg;

  // Fixed field widths
  localparam int PIX_W    = 8;
  localparam int ROW_W    = 13;
  localparam int CFG_DW   = 13;
  localparam int WID_W    = 12;
  localparam int VS_W     = 15;
  localparam int CS_W     = 21;
  localparam int SLOT_W   = 3;

  // Line store geometry: one column word holds one pixel of each stored row
  localparam int LANES    = 5;
  localparam int WORD_W   = LANES * PIX_W;

  // Border before the first output position, in both directions
  localparam int LEAD     = 5;
  // Padding rows/columns beyond the output size, minus one
  localparam int PAD_LAST = 4;

  localparam int MAX_HEIGHT   = 4096;
  localparam int RESET_WIDTH  = 16;
  localparam int RESET_HEIGHT = 16;

  // Register indexes
  typedef enum logic [0:0] {
    REG_PLANE_WIDTH  = 1'b0,
    REG_PLANE_HEIGHT = 1'b1
  } lhp_reg_t;

  // Control that travels with an item through the pipeline
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              emit;
    logic              last;
  } lhp_tag_t;

  // Six-tap (1,-5,20,20,-5,1) over pixels
  function automatic logic signed [VS_W-1:0] six_tap_pix(
    input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] c,
    input logic [PIX_W-1:0] d, input logic [PIX_W-1:0] e, input logic [PIX_W-1:0] f);
    logic signed [VS_W-1:0] ea, eb, ec, ed, ee, ef;
    begin
      ea = $signed({{(VS_W-PIX_W){1'b0}}, a});
      eb = $signed({{(VS_W-PIX_W){1'b0}}, b});
      ec = $signed({{(VS_W-PIX_W){1'b0}}, c});
      ed = $signed({{(VS_W-PIX_W){1'b0}}, d});
      ee = $signed({{(VS_W-PIX_W){1'b0}}, e});
      ef = $signed({{(VS_W-PIX_W){1'b0}}, f});
      return ea + ef - 15'sd5 * (eb + ee) + 15'sd20 * (ec + ed);
    end
  endfunction

  // Six-tap over signed vertical sums
  function automatic logic signed [CS_W-1:0] six_tap_vs(
    input logic signed [VS_W-1:0] a, input logic signed [VS_W-1:0] b,
    input logic signed [VS_W-1:0] c, input logic signed [VS_W-1:0] d,
    input logic signed [VS_W-1:0] e, input logic signed [VS_W-1:0] f);
    logic signed [CS_W-1:0] ea, eb, ec, ed, ee, ef;
    begin
      ea = CS_W'(a);
      eb = CS_W'(b);
      ec = CS_W'(c);
      ed = CS_W'(d);
      ee = CS_W'(e);
      ef = CS_W'(f);
      return ea + ef - 21'sd5 * (eb + ee) + 21'sd20 * (ec + ed);
    end
  endfunction

  // (s+16)>>5, clipped to 0..255
  function automatic logic [PIX_W-1:0] clip_sh5(input logic signed [VS_W-1:0] s);
    logic signed [VS_W:0] t;
    begin
      t = (VS_W+1)'(s) + 16'sd16;
      if (t[VS_W]) return '0;
      else if (t[VS_W-1:5] > 10'd255) return 8'd255;
      else return t[12:5];
    end
  endfunction

  // (s+512)>>10, clipped to 0..255
  function automatic logic [PIX_W-1:0] clip_sh10(input logic signed [CS_W-1:0] s);
    logic signed [CS_W:0] t;
    begin
      t = (CS_W+1)'(s) + 22'sd512;
      if (t[CS_W]) return '0;
      else if (t[CS_W-1:10] > 11'd255) return 8'd255;
      else return t[17:10];
    end
  endfunction

endpackage

@@ hw/rtl/lhp_column_stage.sv @@
`timescale 1ns / 1ps

// Line store and vertical filter. Each column word holds five stored rows,
// lane j carrying the row whose index mod 5 is j. One read per accepted pixel,
// the same word written back one stage later with the new pixel merged in.
module lhp_column_stage #(
  parameter int LINE_LEN = 2053,
  parameter int CW       = 12
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              rd_en,
  input  logic [CW-1:0]                     rd_col,
  input  logic [lhp_pkg::PIX_W-1:0]         rd_pixel,
  input  lhp_pkg::lhp_tag_t                 rd_tag,
  input  logic                              take,
  output logic                              b_valid,
  output logic [lhp_pkg::PIX_W-1:0]         b_mid,
  output logic signed [lhp_pkg::VS_W-1:0]   b_vs,
  output lhp_pkg::lhp_tag_t                 b_tag
);

  logic [lhp_pkg::WORD_W-1:0] mem [LINE_LEN];
  logic [lhp_pkg::WORD_W-1:0] rdata;
  logic [lhp_pkg::WORD_W-1:0] wdata;
  logic [lhp_pkg::PIX_W-1:0]  b_pixel;
  logic [CW-1:0]              b_col;
  logic [lhp_pkg::PIX_W-1:0]  r [lhp_pkg::LANES];
  logic                       wr_en;

  // Column word read, held while the stage stalls
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[rd_col];
    end
  end

  // Write-back of the merged word. A column is read again only a full row
  // later (at least six pixels), so the write always lands first.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[b_col] <= wdata;
    end
  end

  assign wr_en = b_valid && take;

  // Stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (rd_en) begin
      b_valid <= 1'b1;
    end else if (take) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      b_pixel <= rd_pixel;
      b_col   <= rd_col;
      b_tag   <= rd_tag;
    end
  end

  // r[k]: stored row py-5+k, taken from lane (slot+k) mod 5
  always_comb begin
    logic [lhp_pkg::SLOT_W:0] lane;
    for (int k = 0; k < lhp_pkg::LANES; k++) begin
      lane = (lhp_pkg::SLOT_W+1)'(b_tag.slot) + (lhp_pkg::SLOT_W+1)'(k);
      if (lane >= (lhp_pkg::SLOT_W+1)'(lhp_pkg::LANES)) begin
        lane = lane - (lhp_pkg::SLOT_W+1)'(lhp_pkg::LANES);
      end
      r[k] = rdata[lane[lhp_pkg::SLOT_W-1:0]*lhp_pkg::PIX_W +: lhp_pkg::PIX_W];
    end
  end

  // Merge the new pixel into its own lane (the oldest row)
  always_comb begin
    wdata = rdata;
    wdata[b_tag.slot*lhp_pkg::PIX_W +: lhp_pkg::PIX_W] = b_pixel;
  end

  assign b_mid = r[2];
  assign b_vs  = lhp_pkg::six_tap_pix(r[0], r[1], r[2], r[3], r[4], b_pixel);

endmodule

@@ hw/rtl/lhp_window_stage.sv @@
`timescale 1ns / 1ps

// Horizontal pixel window and vertical sum window, then rounding, clipping
// and the output register.
module lhp_window_stage (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              load,
  input  logic [lhp_pkg::PIX_W-1:0]         mid,
  input  logic signed [lhp_pkg::VS_W-1:0]   vs,
  input  lhp_pkg::lhp_tag_t                 tag,
  output logic                              take,
  input  logic                              res_stall,
  output logic                              res_valid,
  output logic [lhp_pkg::PIX_W-1:0]         half_h,
  output logic [lhp_pkg::PIX_W-1:0]         half_v,
  output logic [lhp_pkg::PIX_W-1:0]         half_c,
  output logic                              last
);

  logic [lhp_pkg::PIX_W-1:0]       row_win [6];
  logic signed [lhp_pkg::VS_W-1:0] vs_win  [6];
  logic                            c_valid;
  logic                            c_last;
  logic                            c_adv;
  logic signed [lhp_pkg::VS_W-1:0] hs;
  logic signed [lhp_pkg::CS_W-1:0] cs;

  assign c_adv = !res_valid || !res_stall;
  // Windows may shift only once the waiting output position has moved on
  assign take  = !c_valid || c_adv;

  // Window shift, one column per item
  always_ff @(posedge clk) begin
    if (load) begin
      for (int k = 0; k < 5; k++) begin
        row_win[k] <= row_win[k+1];
        vs_win[k]  <= vs_win[k+1];
      end
      row_win[5] <= mid;
      vs_win[5]  <= vs;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (load) begin
      c_valid <= tag.emit;
    end else if (c_adv) begin
      c_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      c_last <= tag.last;
    end
  end

  // Filter sums over the windows
  assign hs = lhp_pkg::six_tap_pix(row_win[0], row_win[1], row_win[2],
                                   row_win[3], row_win[4], row_win[5]);
  assign cs = lhp_pkg::six_tap_vs(vs_win[0], vs_win[1], vs_win[2],
                                  vs_win[3], vs_win[4], vs_win[5]);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (c_adv) begin
      res_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_valid && c_adv) begin
      half_h <= lhp_pkg::clip_sh5(hs);
      half_v <= lhp_pkg::clip_sh5(vs_win[2]);
      half_c <= lhp_pkg::clip_sh10(cs);
      last   <= c_last;
    end
  end

endmodule

@@ hw/rtl/luma_half_pel_interpolator_top.sv @@
`timescale 1ns / 1ps

// Six-tap luma half-pel interpolator. Feed the padded plane, (width+5) by
// (height+5) pixels in raster order; for each full-pel position the block
// returns the horizontal, vertical and centre half-pel samples, clipped to
// 0..255, with last set on the final position of the plane. It takes one
// pixel per clock sustained while res_stall is low; each result passes the
// column, window and output registers. The rate is set by the line store, a
// single memory of MAX_WIDTH+5 words of 40 bits with one read and one write
// port: every pixel does one read-modify-write of its column word. The store
// needs no clearing after reset. Writing a register restarts the plane; write
// only while the block is idle.
module luma_half_pel_interpolator_top #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            src_valid,
  output logic                            src_stall,
  input  logic [lhp_pkg::PIX_W-1:0]       pixel,
  output logic                            res_valid,
  input  logic                            res_stall,
  output logic [lhp_pkg::PIX_W-1:0]       half_h,
  output logic [lhp_pkg::PIX_W-1:0]       half_v,
  output logic [lhp_pkg::PIX_W-1:0]       half_c,
  output logic                            last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [0:0]                      cfg_index,
  input  logic [lhp_pkg::CFG_DW-1:0]      cfg_data
);

  localparam int LINE_LEN = MAX_WIDTH + lhp_pkg::LEAD;
  localparam int CW       = $clog2(LINE_LEN);

  logic [CW-1:0]                   col;
  logic [lhp_pkg::ROW_W-1:0]       row;
  logic [lhp_pkg::SLOT_W-1:0]      slot;
  logic [CW-1:0]                   last_col;
  logic [lhp_pkg::ROW_W-1:0]       last_row;
  logic [CW-1:0]                   cfg_last_col;
  logic [lhp_pkg::ROW_W-1:0]       cfg_last_row;
  logic                            in_fire;
  logic                            cfg_fire;
  logic                            take;
  logic                            b_valid;
  logic [lhp_pkg::PIX_W-1:0]       b_mid;
  logic signed [lhp_pkg::VS_W-1:0] b_vs;
  lhp_pkg::lhp_tag_t               rd_tag;
  lhp_pkg::lhp_tag_t               b_tag;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign src_stall = b_valid && !take;
  assign in_fire   = src_valid && !src_stall;

  // Effective size: zero means one, too large saturates
  always_comb begin
    int w;
    int h;
    w = int'(cfg_data[lhp_pkg::WID_W-1:0]);
    h = int'(cfg_data);
    if (w == 0) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (h == 0) h = 1;
    if (h > lhp_pkg::MAX_HEIGHT) h = lhp_pkg::MAX_HEIGHT;
    cfg_last_col = CW'(w + lhp_pkg::PAD_LAST);
    cfg_last_row = lhp_pkg::ROW_W'(h + lhp_pkg::PAD_LAST);
  end

  // Size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      last_col <= CW'(lhp_pkg::RESET_WIDTH + lhp_pkg::PAD_LAST);
      last_row <= lhp_pkg::ROW_W'(lhp_pkg::RESET_HEIGHT + lhp_pkg::PAD_LAST);
    end else if (cfg_fire) begin
      unique case (lhp_pkg::lhp_reg_t'(cfg_index))
        lhp_pkg::REG_PLANE_WIDTH:  last_col <= cfg_last_col;
        lhp_pkg::REG_PLANE_HEIGHT: last_row <= cfg_last_row;
        default: ;
      endcase
    end
  end

  // Position counters; slot tracks row mod 5
  always_ff @(posedge clk) begin
    if (rst || cfg_fire) begin
      col  <= '0;
      row  <= '0;
      slot <= '0;
    end else if (in_fire) begin
      if (col == last_col) begin
        col <= '0;
        if (row == last_row) begin
          row  <= '0;
          slot <= '0;
        end else begin
          row  <= row + 1'b1;
          slot <= (slot == lhp_pkg::SLOT_W'(lhp_pkg::LANES - 1)) ? '0 : slot + 1'b1;
        end
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  assign rd_tag.slot = slot;
  assign rd_tag.emit = (col >= CW'(lhp_pkg::LEAD)) && (row >= lhp_pkg::ROW_W'(lhp_pkg::LEAD));
  assign rd_tag.last = (col == last_col) && (row == last_row);

  lhp_column_stage #(
    .LINE_LEN (LINE_LEN),
    .CW       (CW)
  ) u_column (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (in_fire),
    .rd_col   (col),
    .rd_pixel (pixel),
    .rd_tag   (rd_tag),
    .take     (take),
    .b_valid  (b_valid),
    .b_mid    (b_mid),
    .b_vs     (b_vs),
    .b_tag    (b_tag)
  );

  lhp_window_stage u_window (
    .clk       (clk),
    .rst       (rst),
    .load      (b_valid && take),
    .mid       (b_mid),
    .vs        (b_vs),
    .tag       (b_tag),
    .take      (take),
    .res_stall (res_stall),
    .res_valid (res_valid),
    .half_h    (half_h),
    .half_v    (half_v),
    .half_c    (half_c),
    .last      (last)
  );

  // The input backs up only when every stage is full behind a stalled result
  assert property (@(posedge clk) disable iff (rst)
    src_stall |-> (res_valid && res_stall))
    else $error("input stalled with a free pipeline");

  assert property (@(posedge clk) disable iff (rst)
    col <= last_col)
    else $error("column counter beyond padded row");

  assert property (@(posedge clk) disable iff (rst)
    (row <= last_row) && (slot < lhp_pkg::SLOT_W'(lhp_pkg::LANES)))
    else $error("row counter or line slot out of range");

endmodule

@@ bench/luma_half_pel_interpolator_top_tb.sv @@
`timescale 1ns / 1ps

module luma_half_pel_interpolator_top_tb;

  localparam int MAX_W        = 2048;
  localparam int LINE_LEN     = MAX_W + lhp_pkg::LEAD;
  localparam int DRAIN_CYCLES = 8;
  localparam int RAND_PIXELS  = 350;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef enum int {
    PAT_ZERO, PAT_FULL, PAT_NEG, PAT_POS, PAT_RAND, PAT_BINARY, PAT_SMOOTH
  } pattern_t;

  typedef struct packed {
    logic [lhp_pkg::PIX_W-1:0] h;
    logic [lhp_pkg::PIX_W-1:0] v;
    logic [lhp_pkg::PIX_W-1:0] c;
    logic                      last;
  } sample_t;

  // One directed plane: register values, fill, and samples typed in where obvious
  typedef struct {
    logic [lhp_pkg::CFG_DW-1:0] w_val;
    logic [lhp_pkg::CFG_DW-1:0] h_val;
    pattern_t                   pat;
    int                         planes;
    bit                         typed;
    logic [lhp_pkg::PIX_W-1:0]  eh;
    logic [lhp_pkg::PIX_W-1:0]  ev;
    logic [lhp_pkg::PIX_W-1:0]  ec;
  } plane_case_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       src_valid = 1'b0;
  logic                       src_stall;
  logic [lhp_pkg::PIX_W-1:0]  pixel = '0;
  logic                       res_valid;
  logic                       res_stall = 1'b0;
  logic [lhp_pkg::PIX_W-1:0]  half_h;
  logic [lhp_pkg::PIX_W-1:0]  half_v;
  logic [lhp_pkg::PIX_W-1:0]  half_c;
  logic                       last;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [0:0]                 cfg_index = lhp_pkg::REG_PLANE_WIDTH;
  logic [lhp_pkg::CFG_DW-1:0] cfg_data = '0;

  // Predictor state
  logic [lhp_pkg::PIX_W-1:0]        line_mem [5][LINE_LEN];
  logic [lhp_pkg::PIX_W-1:0]        pix_win [6];
  logic signed [lhp_pkg::VS_W-1:0]  vsum_win [6];
  logic [lhp_pkg::WID_W-1:0]        col_pos;
  logic [lhp_pkg::ROW_W-1:0]        row_pos;
  logic [lhp_pkg::WID_W-1:0]        width_reg;
  logic [lhp_pkg::ROW_W-1:0]        height_reg;
  sample_t                          pending_samples [$];

  bit                         typed_on;
  logic [lhp_pkg::PIX_W-1:0]  typed_h, typed_v, typed_c;

  int src_idle_pct;
  int res_stall_pct;
  int fail_count;
  int samples_checked;
  int pixels_sent;
  int planes_sent;
  int reg_writes;
  int cycle_count;

  plane_case_t plane_cases [5];

  luma_half_pel_interpolator_top #(.MAX_WIDTH(MAX_W)) u_top (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .pixel     (pixel),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .half_h    (half_h),
    .half_v    (half_v),
    .half_c    (half_c),
    .last      (last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Effective plane size after zero and saturation handling
  function automatic int eff_width();
    int w;
    w = width_reg;
    if (w == 0) w = 1;
    if (w > MAX_W) w = MAX_W;
    return w;
  endfunction

  function automatic int eff_height();
    int h;
    h = height_reg;
    if (h == 0) h = 1;
    if (h > lhp_pkg::MAX_HEIGHT) h = lhp_pkg::MAX_HEIGHT;
    return h;
  endfunction

  function automatic int tap6(int a, int b, int c, int d, int e, int f);
    return a + f - 5 * (b + e) + 20 * (c + d);
  endfunction

  function automatic logic [lhp_pkg::PIX_W-1:0] round_sat(int s, int bias, int sh);
    int t;
    t = s + bias;
    if (t < 0) return '0;
    t = t >> sh;
    if (t > 255) return 8'd255;
    return t[lhp_pkg::PIX_W-1:0];
  endfunction

  // Advance the predicted block by one accepted pixel
  task automatic interpolate_pixel(input logic [lhp_pkg::PIX_W-1:0] cur);
    int w, h, px, py, hs, cs;
    int r [5];
    logic signed [lhp_pkg::VS_W-1:0] vs;
    sample_t s;
    w  = eff_width();
    h  = eff_height();
    px = col_pos;
    py = row_pos;
    // column of the five stored rows, oldest first
    for (int k = 0; k < 5; k++) r[k] = line_mem[(py + k) % 5][px];
    vs = lhp_pkg::VS_W'(tap6(r[0], r[1], r[2], r[3], r[4], int'(cur)));
    for (int k = 0; k < 5; k++) begin
      pix_win[k]  = pix_win[k+1];
      vsum_win[k] = vsum_win[k+1];
    end
    pix_win[5]  = r[2][lhp_pkg::PIX_W-1:0];
    vsum_win[5] = vs;
    line_mem[py % 5][px] = cur;
    if (px >= lhp_pkg::LEAD && py >= lhp_pkg::LEAD) begin
      hs = tap6(pix_win[0], pix_win[1], pix_win[2], pix_win[3], pix_win[4], pix_win[5]);
      cs = tap6(vsum_win[0], vsum_win[1], vsum_win[2], vsum_win[3], vsum_win[4],
                vsum_win[5]);
      s.h    = round_sat(hs, 16, 5);
      s.v    = round_sat(vsum_win[2], 16, 5);
      s.c    = round_sat(cs, 512, 10);
      s.last = (px == w + lhp_pkg::PAD_LAST) && (py == h + lhp_pkg::PAD_LAST);
      if (typed_on) begin
        s.h = typed_h;
        s.v = typed_v;
        s.c = typed_c;
      end
      pending_samples.push_back(s);
    end
    // raster position, wrapping at the end of the padded plane
    px++;
    if (px >= w + lhp_pkg::LEAD) begin
      px = 0;
      py++;
      if (py >= h + lhp_pkg::LEAD) py = 0;
    end
    col_pos = px[lhp_pkg::WID_W-1:0];
    row_pos = py[lhp_pkg::ROW_W-1:0];
  endtask

  task automatic compare_field(input string name, input logic [lhp_pkg::PIX_W-1:0] want,
                               input logic [lhp_pkg::PIX_W-1:0] got);
    if (got !== want) begin
      fail_count++;
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
    end
  endtask

  // Result side: check each accepted result against the oldest pending sample
  task automatic check_sample();
    sample_t want;
    samples_checked++;
    if (pending_samples.size() == 0) begin
      fail_count++;
      $error("result arrived with no sample pending");
    end else begin
      want = pending_samples.pop_front();
      compare_field("half_h", want.h, half_h);
      compare_field("half_v", want.v, half_v);
      compare_field("half_c", want.c, half_c);
      compare_field("last", {7'd0, want.last}, {7'd0, last});
    end
  endtask

  always @(posedge clk) begin
    if (res_valid === 1'b1 && !res_stall) check_sample();
    res_stall <= ($urandom_range(99) < res_stall_pct);
  end

  // Idle modes: none, sender idle, receiver stalling, both
  task automatic set_idle(input int mode);
    case (mode)
      0: begin src_idle_pct = 0;  res_stall_pct = 0;  end
      1: begin src_idle_pct = 47; res_stall_pct = 0;  end
      2: begin src_idle_pct = 0;  res_stall_pct = 47; end
      default: begin src_idle_pct = 20; res_stall_pct = 20; end
    endcase
  endtask

  // Source side: hold the pixel request until it is taken
  task automatic send_pixel(input logic [lhp_pkg::PIX_W-1:0] p);
    while ($urandom_range(99) < src_idle_pct) begin
      src_valid <= 1'b0;
      @(posedge clk);
    end
    src_valid <= 1'b1;
    pixel     <= p;
    do @(posedge clk); while (src_stall);
    interpolate_pixel(p);
    pixels_sent++;
  endtask

  // Wait until the block has nothing left in flight
  task automatic drain();
    src_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_valid high; configure lowers it after the last request
  task automatic write_reg(input lhp_pkg::lhp_reg_t idx,
                           input logic [lhp_pkg::CFG_DW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == lhp_pkg::REG_PLANE_WIDTH) width_reg = val[lhp_pkg::WID_W-1:0];
    else height_reg = val[lhp_pkg::ROW_W-1:0];
    col_pos = '0;
    row_pos = '0;
    reg_writes++;
  endtask

  task automatic configure(input bit set_w, input logic [lhp_pkg::CFG_DW-1:0] w_val,
                           input bit set_h, input logic [lhp_pkg::CFG_DW-1:0] h_val);
    drain();
    if (set_w) write_reg(lhp_pkg::REG_PLANE_WIDTH, w_val);
    if (set_h) write_reg(lhp_pkg::REG_PLANE_HEIGHT, h_val);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [lhp_pkg::PIX_W-1:0] pattern_pixel(pattern_t pat, int x, int y,
                                                              int base);
    int v;
    case (pat)
      PAT_ZERO:   return 8'd0;
      PAT_FULL:   return 8'd255;
      // bright on the -5 taps only: every sum goes negative
      PAT_NEG:    return (x == 1 || x == 4 || y == 1 || y == 4) ? 8'd255 : 8'd0;
      PAT_POS:    return (x == 2 || x == 3 || y == 2 || y == 3) ? 8'd255 : 8'd0;
      PAT_BINARY: return $urandom_range(1) ? 8'd255 : 8'd0;
      PAT_SMOOTH: begin
        v = base + int'($urandom_range(16)) - 8;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[lhp_pkg::PIX_W-1:0];
      end
      default:    return lhp_pkg::PIX_W'($urandom_range(255));
    endcase
  endfunction

  // Feed one padded plane in raster order; stop_after > 0 cuts it short
  task automatic send_plane(input pattern_t pat, input int stop_after);
    int w, h, n, base;
    w    = eff_width();
    h    = eff_height();
    n    = 0;
    base = $urandom_range(255);
    planes_sent++;
    for (int y = 0; y < h + lhp_pkg::LEAD; y++) begin
      for (int x = 0; x < w + lhp_pkg::LEAD; x++) begin
        if (stop_after > 0 && n >= stop_after) return;
        send_pixel(pattern_pixel(pat, x, y, base));
        n++;
      end
    end
  endtask

  function automatic pattern_t pick_pattern();
    case ($urandom_range(9))
      0, 1, 2, 3: return PAT_RAND;
      4, 5:       return PAT_BINARY;
      6, 7:       return PAT_SMOOTH;
      8:          return PAT_FULL;
      default:    return PAT_ZERO;
    endcase
  endfunction

  // Run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int rand_start, total, stop;
    bit restart;
    logic [lhp_pkg::WID_W-1:0] new_w;
    logic [lhp_pkg::CFG_DW-1:0] new_h;

    // predictor reset state
    for (int s = 0; s < 5; s++)
      for (int c = 0; c < LINE_LEN; c++) line_mem[s][c] = '0;
    for (int k = 0; k < 6; k++) begin
      pix_win[k]  = '0;
      vsum_win[k] = '0;
    end
    col_pos    = '0;
    row_pos    = '0;
    width_reg  = lhp_pkg::RESET_WIDTH;
    height_reg = lhp_pkg::RESET_HEIGHT;
    typed_on   = 1'b0;
    fail_count = 0;
    set_idle(0);

    // minimal planes first; uniform fills give obvious samples
    plane_cases[0] = '{13'd1, 13'd1, PAT_ZERO, 1, 1'b1, 8'd0,   8'd0,   8'd0};
    plane_cases[1] = '{13'd1, 13'd1, PAT_FULL, 1, 1'b1, 8'd255, 8'd255, 8'd255};
    plane_cases[2] = '{13'd1, 13'd1, PAT_NEG,  1, 1'b1, 8'd0,   8'd0,   8'd0};
    // zero size reads as one
    plane_cases[3] = '{13'd0, 13'd0, PAT_POS,  1, 1'b0, 8'd0,   8'd0,   8'd0};
    // two planes back to back across the end-of-plane wrap
    plane_cases[4] = '{13'd3, 13'd2, PAT_FULL, 2, 1'b1, 8'd255, 8'd255, 8'd255};

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed planes
    for (int i = 0; i < 5; i++) begin
      set_idle(i % 4);
      configure(1'b1, plane_cases[i].w_val, 1'b1, plane_cases[i].h_val);
      typed_on = plane_cases[i].typed;
      typed_h  = plane_cases[i].eh;
      typed_v  = plane_cases[i].ev;
      typed_c  = plane_cases[i].ec;
      repeat (plane_cases[i].planes) send_plane(plane_cases[i].pat, 0);
      typed_on = 1'b0;
    end

    // Random small planes, some cut short and restarted by a register write
    rand_start = pixels_sent;
    restart    = 1'b1;
    while (pixels_sent - rand_start < RAND_PIXELS) begin
      set_idle(((pixels_sent - rand_start) * 4) / RAND_PIXELS);
      if (restart || $urandom_range(2) != 0) begin
        new_w = ($urandom_range(9) == 0) ? 12'd0 : lhp_pkg::WID_W'($urandom_range(8, 1));
        new_h = ($urandom_range(9) == 0) ? 13'd0 : lhp_pkg::CFG_DW'($urandom_range(4, 1));
        // bit 12 of the width write is outside the register
        configure(1'b1, {1'($urandom_range(1)), new_w}, 1'($urandom_range(1)), new_h);
      end
      total   = (eff_width() + lhp_pkg::LEAD) * (eff_height() + lhp_pkg::LEAD);
      stop    = 0;
      restart = 1'b0;
      if ($urandom_range(5) == 0) begin
        stop    = $urandom_range(total - 1, 1);
        restart = 1'b1;
      end
      send_plane(pick_pattern(), stop);
    end

    // Saturating sizes, cut short: width above the line store, then height above 4096
    set_idle($urandom_range(3));
    configure(1'b1, 13'h1FFF, 1'b1, 13'd1);
    send_plane(PAT_RAND, 40);
    set_idle($urandom_range(3));
    configure(1'b1, 13'd1, 1'b1, 13'h1FFF);
    send_plane(PAT_BINARY, 120);

    drain();
    $display("Covered %0d pixels over %0d planes with %0d register writes; %0d samples compared.",
             pixels_sent, planes_sent, reg_writes, samples_checked);
    $display("Plane sizes from 1x1 up to saturated width and height, under four idle modes.");
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
